// ===== design/wthit_pkg.sv =====
package wthit_pkg;

   localparam int MAX_WINDOWS_DEF = 16;
   localparam logic [7:0] TITLEBAR_HEIGHT_RESET = 8'd24;

   localparam logic [2:0] OP_CREATE  = 3'd0;
   localparam logic [2:0] OP_DESTROY = 3'd1;
   localparam logic [2:0] OP_RAISE   = 3'd2;
   localparam logic [2:0] OP_MOVE    = 3'd3;
   localparam logic [2:0] OP_SHADE   = 3'd4;
   localparam logic [2:0] OP_HIT     = 3'd5;

   localparam logic [15:0] ID_FIRST = 16'd1;
   localparam logic [15:0] ID_LAST  = 16'hFFFF;
   localparam logic [31:0] DEPTH_FIRST = 32'd1;
   localparam logic [31:0] DEPTH_MAX   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] x;
      logic [15:0] y;
      logic [11:0] w;
      logic [11:0] h;
      logic [31:0] depth;
      logic [7:0]  owner;
      logic        decorated;
      logic        shaded;
   } entry_type;

endpackage

// ===== design/window_table_z_hit_test_top.sv =====
// create and unknown operations pass through the execute state and then the wait state,
// which raises rsp_valid once the output register is free
// id lookups and hit test read one table entry per cycle through the single read port
// of the entry memory, whose read data is registered; a lookup ends at its id match
// one word at a time: req_ready is low until the answer has moved to the output register
// reset: all slots free, id and depth counters at one, titlebar height 24, memory not cleared
module window_table_z_hit_test_top #(
   parameter int MAX_WINDOWS = wthit_pkg::MAX_WINDOWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic [15:0]        req_window_id,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [11:0]        req_width,
   input  logic [11:0]        req_height,
   input  logic [7:0]         req_owner_tag,
   input  logic               req_has_title_bar,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_ok,
   output logic [15:0]        rsp_result_id,
   output logic               rsp_shaded_now
);
   import wthit_pkg::*;

   localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int CW = $clog2(MAX_WINDOWS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_WINDOWS - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_WINDOWS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_WAIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [MAX_WINDOWS-1:0] valid_ff, valid_in;
   logic [CW-1:0]          live_ff, live_in;
   logic [15:0]            next_id_ff, next_id_in;
   logic [31:0]            next_depth_ff, next_depth_in;
   logic [7:0]             tbh_ff;

   logic [2:0]         op_ff;
   logic [15:0]        id_ff;
   logic signed [15:0] px_ff, py_ff;
   logic [11:0]        w_ff, h_ff;
   logic [7:0]         own_ff;
   logic               dec_ff;

   logic [IW-1:0] addr_ff, addr_in;
   logic          issue_done_ff, issue_done_in;
   logic          rd_valid_ff;
   logic [IW-1:0] rd_idx_ff;
   entry_type     rd_data_ff;
   logic          rd_en;

   logic          found_ff, found_in;
   logic [31:0]   best_ff, best_in;
   logic [15:0]   best_id_ff, best_id_in;

   logic          res_ok_ff, res_ok_in;
   logic [15:0]   res_id_ff, res_id_in;
   logic          res_sh_ff, res_sh_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [15:0]   rsp_id_ff, rsp_id_in;
   logic          rsp_sh_ff, rsp_sh_in;

   entry_type     mem [MAX_WINDOWS];
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;

   logic [IW-1:0]      free_idx;
   logic               rd_live;
   logic               id_match;
   logic               contains;
   logic               cand;
   logic [12:0]        frame_h;
   logic signed [17:0] px18, py18, x0, x1, y0, y1;
   logic [31:0]        depth_take;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   // frame of the entry on the read port
   always_comb begin
      if (!rd_data_ff.decorated) begin
         frame_h = {1'b0, rd_data_ff.h};
      end else if (rd_data_ff.shaded) begin
         frame_h = {5'b0, tbh_ff};
      end else begin
         frame_h = {1'b0, rd_data_ff.h} + {5'b0, tbh_ff};
      end
      px18 = 18'(px_ff);
      py18 = 18'(py_ff);
      x0 = $signed({{2{rd_data_ff.x[15]}}, rd_data_ff.x});
      y0 = $signed({{2{rd_data_ff.y[15]}}, rd_data_ff.y});
      x1 = x0 + $signed({6'b0, rd_data_ff.w});
      y1 = y0 + $signed({5'b0, frame_h});
      contains = (px18 >= x0) && (px18 < x1) && (py18 >= y0) && (py18 < y1);
   end

   assign rd_live    = valid_ff[rd_idx_ff];
   assign id_match   = rd_live && (rd_data_ff.id == id_ff);
   assign cand       = rd_live && (!found_ff || (rd_data_ff.depth > best_ff)) && contains;
   assign depth_take = (next_depth_ff != DEPTH_MAX) ? next_depth_ff + 32'd1 : next_depth_ff;

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      live_in       = live_ff;
      next_id_in    = next_id_ff;
      next_depth_in = next_depth_ff;
      addr_in       = addr_ff;
      issue_done_in = issue_done_ff;
      rd_en         = 1'b0;
      found_in      = found_ff;
      best_in       = best_ff;
      best_id_in    = best_id_ff;
      res_ok_in     = res_ok_ff;
      res_id_in     = res_id_ff;
      res_sh_in     = res_sh_ff;
      mem_we        = 1'b0;
      mem_waddr     = rd_idx_ff;
      mem_wdata     = rd_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_sh_in     = rsp_sh_ff;
      req_ready     = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               addr_in       = '0;
               issue_done_in = 1'b0;
               found_in      = 1'b0;
               if (req_operation == OP_CREATE || req_operation > OP_HIT) begin
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_EXEC: begin
            res_ok_in = 1'b0;
            res_id_in = '0;
            res_sh_in = 1'b0;
            if (op_ff == OP_CREATE && live_ff != FULL_COUNT) begin
               mem_we              = 1'b1;
               mem_waddr           = free_idx;
               mem_wdata.id        = next_id_ff;
               mem_wdata.x         = px_ff;
               mem_wdata.y         = py_ff;
               mem_wdata.w         = w_ff;
               mem_wdata.h         = h_ff;
               mem_wdata.depth     = next_depth_ff;
               mem_wdata.owner     = own_ff;
               mem_wdata.decorated = dec_ff;
               mem_wdata.shaded    = 1'b0;
               valid_in[free_idx]  = 1'b1;
               live_in             = live_ff + CW'(1);
               next_id_in          = (next_id_ff >= ID_LAST) ? ID_FIRST : next_id_ff + 16'd1;
               next_depth_in       = depth_take;
               res_ok_in           = 1'b1;
               res_id_in           = next_id_ff;
            end
            state_in = ST_WAIT;
         end
         ST_SCAN: begin
            if (!issue_done_ff) begin
               rd_en   = 1'b1;
               addr_in = addr_ff + IW'(1);
               if (addr_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end
            end
            if (rd_valid_ff) begin
               if (op_ff == OP_HIT) begin
                  if (cand) begin
                     found_in   = 1'b1;
                     best_in    = rd_data_ff.depth;
                     best_id_in = rd_data_ff.id;
                  end
                  if (rd_idx_ff == LAST_IDX) begin
                     res_ok_in = found_ff || cand;
                     res_id_in = cand ? rd_data_ff.id : (found_ff ? best_id_ff : 16'd0);
                     res_sh_in = 1'b0;
                     state_in  = ST_WAIT;
                  end
               end else if (id_match) begin
                  res_ok_in = 1'b1;
                  res_id_in = '0;
                  res_sh_in = 1'b0;
                  state_in  = ST_WAIT;
                  unique case (op_ff)
                     OP_DESTROY: begin
                        valid_in[rd_idx_ff] = 1'b0;
                        if (live_ff != '0) begin
                           live_in = live_ff - CW'(1);
                        end
                     end
                     OP_RAISE: begin
                        mem_we          = 1'b1;
                        mem_wdata.depth = next_depth_ff;
                        next_depth_in   = depth_take;
                     end
                     OP_MOVE: begin
                        mem_we      = 1'b1;
                        mem_wdata.x = px_ff;
                        mem_wdata.y = py_ff;
                     end
                     default: begin
                        mem_we           = 1'b1;
                        mem_wdata.shaded = !rd_data_ff.shaded;
                        res_sh_in        = !rd_data_ff.shaded;
                     end
                  endcase
               end else if (rd_idx_ff == LAST_IDX) begin
                  res_ok_in = 1'b0;
                  res_id_in = '0;
                  res_sh_in = 1'b0;
                  state_in  = ST_WAIT;
               end
            end
         end
         default: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_id_in    = res_id_ff;
               rsp_sh_in    = res_sh_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         live_ff       <= '0;
         next_id_ff    <= ID_FIRST;
         next_depth_ff <= DEPTH_FIRST;
         tbh_ff        <= TITLEBAR_HEIGHT_RESET;
         issue_done_ff <= 1'b1;
         rd_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         live_ff       <= live_in;
         next_id_ff    <= next_id_in;
         next_depth_ff <= next_depth_in;
         if (csr_wr_en) begin
            tbh_ff <= csr_wr_data;
         end
         issue_done_ff <= issue_done_in;
         rd_valid_ff   <= rd_en;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= req_operation;
         id_ff  <= req_window_id;
         px_ff  <= req_pos_x;
         py_ff  <= req_pos_y;
         w_ff   <= req_width;
         h_ff   <= req_height;
         own_ff <= req_owner_tag;
         dec_ff <= req_has_title_bar;
      end
      addr_ff    <= addr_in;
      rd_idx_ff  <= addr_ff;
      best_ff    <= best_in;
      best_id_ff <= best_id_in;
      res_ok_ff  <= res_ok_in;
      res_id_ff  <= res_id_in;
      res_sh_ff  <= res_sh_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_sh_ff  <= rsp_sh_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_result_id  = rsp_id_ff;
   assign rsp_shaded_now = rsp_sh_ff;

   a_live_count: assert property (@(posedge clock) disable iff (reset)
      live_ff == CW'($countones(valid_ff)))
      else $error("live count disagrees with valid slots");

   a_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_id_ff != 16'd0)
      else $error("id counter reached zero");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_EXEC || state_ff == ST_SCAN))
      else $error("table written outside an operation");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC || state_ff == ST_SCAN))
      else $error("accepted word did not start an operation");

endmodule

// ===== sim/window_table_z_hit_test_checker.sv =====
module window_table_z_hit_test_checker #(
   parameter int MAX_WINDOWS = wthit_pkg::MAX_WINDOWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic [15:0]        req_window_id,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [11:0]        req_width,
   input  logic [11:0]        req_height,
   input  logic [7:0]         req_owner_tag,
   input  logic               req_has_title_bar,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_ok,
   input  logic [15:0]        rsp_result_id,
   input  logic               rsp_shaded_now,
   output int                 fail_count,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import wthit_pkg::*;

   typedef struct packed {
      logic        ok;
      logic [15:0] id;
      logic        shaded;
   } window_answer_type;

   window_answer_type pending_answers[$];
   entry_type      tbl[MAX_WINDOWS];
   logic           tbl_live[MAX_WINDOWS];
   logic [15:0]    next_id;
   logic [31:0]    next_depth;
   logic [7:0]     bar_height;

   task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] seen);
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
      fail_count++;
   endtask

   function automatic int lookup_window(logic [15:0] wid);
      for (int i = 0; i < MAX_WINDOWS; i++) begin
         if (tbl_live[i] && tbl[i].id == wid) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic logic [31:0] claim_depth();
      logic [31:0] d;
      d = next_depth;
      if (next_depth != DEPTH_MAX) begin
         next_depth = next_depth + 1;
      end
      return d;
   endfunction

   function automatic logic frame_holds(int s, int px, int py);
      int fx, fy, fw, fh;
      fx = int'($signed(tbl[s].x));
      fy = int'($signed(tbl[s].y));
      fw = int'(tbl[s].w);
      // shading only collapses a decorated window to its title bar
      if (!tbl[s].decorated) begin
         fh = int'(tbl[s].h);
      end else if (tbl[s].shaded) begin
         fh = int'(bar_height);
      end else begin
         fh = int'(tbl[s].h) + int'(bar_height);
      end
      return px >= fx && px < fx + fw && py >= fy && py < fy + fh;
   endfunction

   function automatic window_answer_type apply_window_op(
      logic [2:0] op, logic [15:0] wid, logic signed [15:0] px, logic signed [15:0] py,
      logic [11:0] in_w, logic [11:0] in_h, logic [7:0] in_owner, logic in_bar);
      window_answer_type ans;
      int             s;
      logic           hit;
      logic [31:0]    top_depth;
      ans = '0;
      s = lookup_window(wid);
      case (op)
         OP_CREATE: begin
            s = -1;
            for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
               if (!tbl_live[i]) begin
                  s = i;
               end
            end
            if (s >= 0) begin
               tbl_live[s]      = 1'b1;
               tbl[s].id        = next_id;
               tbl[s].x         = px;
               tbl[s].y         = py;
               tbl[s].w         = in_w;
               tbl[s].h         = in_h;
               tbl[s].depth     = claim_depth();
               tbl[s].owner     = in_owner;
               tbl[s].decorated = in_bar;
               tbl[s].shaded    = 1'b0;
               ans.ok = 1'b1;
               ans.id = next_id;
               next_id = (next_id == ID_LAST) ? ID_FIRST : next_id + 16'd1;
            end
         end
         OP_DESTROY: begin
            if (s >= 0) begin
               tbl_live[s] = 1'b0;
               ans.ok = 1'b1;
            end
         end
         OP_RAISE: begin
            if (s >= 0) begin
               tbl[s].depth = claim_depth();
               ans.ok = 1'b1;
            end
         end
         OP_MOVE: begin
            if (s >= 0) begin
               tbl[s].x = px;
               tbl[s].y = py;
               ans.ok = 1'b1;
            end
         end
         OP_SHADE: begin
            if (s >= 0) begin
               tbl[s].shaded = !tbl[s].shaded;
               ans.ok = 1'b1;
               ans.shaded = tbl[s].shaded;
            end
         end
         OP_HIT: begin
            hit = 1'b0;
            top_depth = '0;
            // strictly deeper wins, so the lowest slot keeps a tie
            for (int i = 0; i < MAX_WINDOWS; i++) begin
               if (tbl_live[i] && !(hit && tbl[i].depth <= top_depth) &&
                   frame_holds(i, int'(px), int'(py))) begin
                  hit = 1'b1;
                  top_depth = tbl[i].depth;
                  ans.id = tbl[i].id;
               end
            end
            ans.ok = hit;
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      window_answer_type want;
      if (reset) begin
         for (int i = 0; i < MAX_WINDOWS; i++) begin
            tbl_live[i] = 1'b0;
         end
         next_id    = ID_FIRST;
         next_depth = DEPTH_FIRST;
         bar_height = TITLEBAR_HEIGHT_RESET;
         pending_answers.delete();
      end else begin
         if (csr_wr_en) begin
            bar_height = csr_wr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("word with nothing expected", 16'd0, rsp_result_id);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_ok !== want.ok) begin
                  report_mismatch("ok", want.ok, rsp_ok);
               end
               if (rsp_result_id !== want.id) begin
                  report_mismatch("result_id", want.id, rsp_result_id);
               end
               if (rsp_shaded_now !== want.shaded) begin
                  report_mismatch("shaded_now", want.shaded, rsp_shaded_now);
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_answers.push_back(apply_window_op(req_operation, req_window_id,
               req_pos_x, req_pos_y, req_width, req_height, req_owner_tag,
               req_has_title_bar));
         end
      end
      outstanding <= pending_answers.size();
   end

endmodule

// ===== sim/tb_window_table_z_hit_test_top.sv =====
module tb_window_table_z_hit_test_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wthit_pkg::*;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam int IDLE_LIMIT     = 400;
   localparam int SETTLE_CYCLES  = MAX_WINDOWS_DEF + 8;
   localparam int FIRST_CHURN_ID = 5;
   localparam int CHURN_PAIRS    = 20;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_WORDS    = 245;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] wid;
      logic [15:0] x;
      logic [15:0] y;
      logic [11:0] w;
      logic [11:0] h;
      logic [7:0]  owner;
      logic        bar;
   } window_cmd_type;

   // negative bar height means draw one at random
   int phase_bar[RANDOM_PHASES]    = '{0, 255, 24, -1, 1, -1};
   int phase_create[RANDOM_PHASES] = '{45, 20, 35, 15, 40, 30};
   int phase_gap[RANDOM_PHASES]    = '{14, 14, 0, 14, 4, 14};
   int phase_stall[RANDOM_PHASES]  = '{14, 0, 14, 14, 3, 14};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [7:0]         csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_operation = '0;
   logic [15:0]        req_window_id = '0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic [11:0]        req_width = '0;
   logic [11:0]        req_height = '0;
   logic [7:0]         req_owner_tag = '0;
   logic               req_has_title_bar = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_ok;
   logic [15:0]        rsp_result_id;
   logic               rsp_shaded_now;
   int                 fail_count;
   int                 outstanding;
   int                 req_max_gap = 14;
   int                 rsp_max_stall = 14;
   int                 idle_cycles = 0;
   logic [15:0]        seen_ids[$];

   always #2 clock = ~clock;

   window_table_z_hit_test_top u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_window_id     (req_window_id),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_width         (req_width),
      .req_height        (req_height),
      .req_owner_tag     (req_owner_tag),
      .req_has_title_bar (req_has_title_bar),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ok            (rsp_ok),
      .rsp_result_id     (rsp_result_id),
      .rsp_shaded_now    (rsp_shaded_now)
   );

   window_table_z_hit_test_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_window_id     (req_window_id),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_width         (req_width),
      .req_height        (req_height),
      .req_owner_tag     (req_owner_tag),
      .req_has_title_bar (req_has_title_bar),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ok            (rsp_ok),
      .rsp_result_id     (rsp_result_id),
      .rsp_shaded_now    (rsp_shaded_now),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   function automatic window_cmd_type make_cmd(logic [2:0] op, logic [15:0] wid, int x, int y,
                                               int w, int h, logic bar);
      window_cmd_type c;
      c.op    = op;
      c.wid   = wid;
      c.x     = 16'(x);
      c.y     = 16'(y);
      c.w     = 12'(w);
      c.h     = 12'(h);
      c.owner = 8'($urandom);
      c.bar   = bar;
      return c;
   endfunction

   function automatic logic [15:0] draw_coord();
      if ($urandom_range(99) < 85) begin
         return 16'(int'($urandom_range(600)) - 300);
      end
      return 16'($urandom);
   endfunction

   function automatic logic [11:0] draw_size();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 6) begin
         return '0;
      end else if (r < 82) begin
         return 12'($urandom_range(320));
      end
      return 12'($urandom);
   endfunction

   function automatic window_cmd_type draw_cmd(int create_pct);
      window_cmd_type c;
      int unsigned r;
      r = $urandom_range(99);
      if (r < create_pct) begin
         c.op = OP_CREATE;
      end else begin
         r = $urandom_range(99);
         if (r < 22) begin
            c.op = OP_DESTROY;
         end else if (r < 38) begin
            c.op = OP_RAISE;
         end else if (r < 52) begin
            c.op = OP_MOVE;
         end else if (r < 68) begin
            c.op = OP_SHADE;
         end else if (r < 97) begin
            c.op = OP_HIT;
         end else begin
            c.op = r[0] ? OP_SPARE_A : OP_SPARE_B;
         end
      end
      r = $urandom_range(99);
      if (seen_ids.size() > 0 && r < 80) begin
         c.wid = seen_ids[$urandom_range(seen_ids.size() - 1)];
      end else if (r < 92) begin
         c.wid = 16'($urandom_range(40));
      end else begin
         c.wid = 16'($urandom);
      end
      c.x     = draw_coord();
      c.y     = draw_coord();
      c.w     = draw_size();
      c.h     = draw_size();
      c.owner = 8'($urandom);
      c.bar   = 1'($urandom);
      return c;
   endfunction

   task automatic send_cmd(window_cmd_type c);
      int unsigned gap;
      gap = $urandom_range(req_max_gap, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= c.op;
      req_window_id     <= c.wid;
      req_pos_x         <= c.x;
      req_pos_y         <= c.y;
      req_width         <= c.w;
      req_height        <= c.h;
      req_owner_tag     <= c.owner;
      req_has_title_bar <= c.bar;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bar_height(logic [7:0] v);
      drain_words();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned stall;
      @(posedge clock);
      forever begin
         stall = $urandom_range(rsp_max_stall, 0);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // ids seen in answers feed the target choice of later words
   always @(negedge clock) begin
      if (rsp_valid && rsp_ready && rsp_ok && rsp_result_id != 16'd0) begin
         seen_ids.push_back(rsp_result_id);
         if (seen_ids.size() > 24) begin
            void'(seen_ids.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("window_table_z_hit_test_top test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int bar;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // extremes, frame shapes, shading, stacking and unknown targets
      send_cmd(make_cmd(OP_HIT, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_CREATE, 0, -32768, -32768, 4095, 4095, 1));
      send_cmd(make_cmd(OP_CREATE, 0, 32767, 32767, 4095, 4095, 0));
      send_cmd(make_cmd(OP_CREATE, 0, 0, 0, 0, 0, 1));
      send_cmd(make_cmd(OP_CREATE, 0, 10, 10, 100, 0, 1));
      send_cmd(make_cmd(OP_HIT, 0, 32767, 32767, 0, 0, 0));
      send_cmd(make_cmd(OP_HIT, 0, -32768, -32768, 0, 0, 0));
      send_cmd(make_cmd(OP_HIT, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_HIT, 0, 50, 20, 0, 0, 0));
      send_cmd(make_cmd(OP_SHADE, 4, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_HIT, 0, 50, 20, 0, 0, 0));
      send_cmd(make_cmd(OP_SHADE, 2, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_HIT, 0, 32767, 32767, 0, 0, 0));
      send_cmd(make_cmd(OP_SHADE, 4, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_RAISE, 1, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_MOVE, 1, 40, 15, 0, 0, 0));
      send_cmd(make_cmd(OP_HIT, 0, 50, 20, 0, 0, 0));
      send_cmd(make_cmd(OP_RAISE, 4, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_HIT, 0, 50, 20, 0, 0, 0));
      send_cmd(make_cmd(OP_DESTROY, 999, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_RAISE, 999, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_MOVE, 999, 7, 7, 0, 0, 0));
      send_cmd(make_cmd(OP_SHADE, 999, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_SPARE_A, 2, 1, 1, 1, 1, 1));
      send_cmd(make_cmd(OP_SPARE_B, 3, 1, 1, 1, 1, 1));
      send_cmd(make_cmd(OP_DESTROY, 1, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_HIT, 0, 50, 20, 0, 0, 0));

      // back to back create and destroy through the lowest free slot
      drain_words();
      req_max_gap   = 0;
      rsp_max_stall = 0;
      for (int n = FIRST_CHURN_ID; n < FIRST_CHURN_ID + CHURN_PAIRS; n++) begin
         send_cmd(make_cmd(OP_CREATE, 0, -1000, -1000, 1, 1, 0));
         send_cmd(make_cmd(OP_DESTROY, 16'(n), 0, 0, 0, 0, 0));
      end
      req_max_gap   = 14;
      rsp_max_stall = 14;
      send_cmd(make_cmd(OP_CREATE, 0, -500, -500, 10, 10, 0));
      send_cmd(make_cmd(OP_CREATE, 0, 300, 300, 20, 20, 0));
      send_cmd(make_cmd(OP_HIT, 0, 305, 305, 0, 0, 0));
      send_cmd(make_cmd(OP_SHADE, 2, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_DESTROY, 2, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_HIT, 0, 305, 305, 0, 0, 0));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         bar = (phase_bar[p] < 0) ? int'($urandom_range(255)) : phase_bar[p];
         write_bar_height(8'(bar));
         req_max_gap   = phase_gap[p];
         rsp_max_stall = phase_stall[p];
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if ($urandom_range(99) < 2) begin
               drain_words();
            end
            send_cmd(draw_cmd(phase_create[p]));
         end
      end

      drain_words();
      if (fail_count == 0) begin
         $display("window_table_z_hit_test_top test passed");
      end else begin
         $display("window_table_z_hit_test_top test failed");
      end
      $finish;
   end

endmodule
